// File: hdl/swmf_pkg.sv
// shared constants, types and widths of the scan window minimum finder
package swmf_pkg;

  localparam int WINDOW_HALF  = 2;
  localparam int MAX_READINGS = 180;
  localparam int SPAN         = 2 * WINDOW_HALF + 1;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 10;
  localparam int SUM_W    = SAMPLE_W + $clog2(SPAN);
  localparam int CNT_W    = $clog2(SPAN + 1);
  localparam int D_W      = $clog2(WINDOW_HALF + 1) > 0 ? $clog2(WINDOW_HALF + 1) : 1;

  localparam int OUT_IDX_W = 10;
  localparam int OUT_SUM_W = 19;
  localparam int OUT_CNT_W = 3;
  localparam int OUT_W     = OUT_IDX_W + OUT_SUM_W + OUT_CNT_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [SAMPLE_W-1:0] CLAMP_RESET = SAMPLE_W'(500);

  typedef logic [SPAN-1:0][SAMPLE_W-1:0] win_t;

  typedef struct packed {
    win_t             win;
    logic [IDX_W-1:0] idx;
    logic             last;
  } q_entry_t;

endpackage

// File: hdl/swmf_front.sv
// front part: clamps readings, keeps the window store and sweep index, issues queue entries
module swmf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [swmf_pkg::SAMPLE_W-1:0]   in_tdata,
  input  logic                            in_tlast,
  input  logic                            cfg_wr_en,
  input  logic [swmf_pkg::SAMPLE_W-1:0]   cfg_wr_data,
  output logic                            push_valid,
  input  logic                            push_ready,
  output swmf_pkg::q_entry_t              push_entry
);

  logic [swmf_pkg::SAMPLE_W-1:0] clamp_r;
  swmf_pkg::win_t                win_r, win_nxt;
  logic [swmf_pkg::IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [swmf_pkg::SAMPLE_W-1:0] clamped;
  logic                          last_eff;
  logic                          accept;

  assign in_tready = push_ready;
  assign accept    = in_tvalid && push_ready;
  assign clamped   = (in_tdata > clamp_r) ? clamp_r : in_tdata;
  assign last_eff  = in_tlast || (cnt_r >= swmf_pkg::IDX_W'(swmf_pkg::MAX_READINGS - 1));

  always_comb begin
    win_nxt[0] = clamped;
    for (int p = 1; p < swmf_pkg::SPAN; p++) begin
      win_nxt[p] = win_r[p-1];
    end
    cnt_nxt = cnt_r + swmf_pkg::IDX_W'(1);
  end

  assign push_valid = in_tvalid;
  assign push_entry = {win_nxt, cnt_r, last_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_r <= swmf_pkg::CLAMP_RESET;
      win_r   <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        clamp_r <= cfg_wr_data;
      end
      if (accept) begin
        if (last_eff) begin
          win_r <= '0;
          cnt_r <= '0;
        end else begin
          win_r <= win_nxt;
          cnt_r <= cnt_nxt;
        end
      end
    end
  end

endmodule

// File: hdl/swmf_queue.sv
// short request queue between the front and back parts
module swmf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  swmf_pkg::q_entry_t wr_entry,
  output logic               rd_valid,
  input  logic               rd_pop,
  output swmf_pkg::q_entry_t rd_entry
);

  swmf_pkg::q_entry_t           mem_r [swmf_pkg::QDEPTH];
  logic [swmf_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [swmf_pkg::QCNT_W-1:0]  cnt_r;
  logic                         do_wr, do_rd;

  assign wr_ready = (cnt_r != swmf_pkg::QCNT_W'(swmf_pkg::QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + swmf_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + swmf_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + swmf_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - swmf_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/swmf_back.sv
// back part: walks window centers, sums windows, keeps the best mean and drives results
module swmf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  swmf_pkg::q_entry_t            head,
  output logic                          head_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [swmf_pkg::OUT_W-1:0]    out_tdata
);

  localparam int W  = swmf_pkg::WINDOW_HALF;
  localparam int IW = swmf_pkg::IDX_W;
  localparam int SW = swmf_pkg::SUM_W;
  localparam int CW = swmf_pkg::CNT_W;
  localparam int DW = swmf_pkg::D_W;
  localparam int PW = SW + CW;

  logic          active_r;
  logic [DW-1:0] d_r;
  logic          stall;
  logic          need_eval, issue;
  logic [DW-1:0] start_d, cur_d;
  logic [IW-1:0] lim, ext;
  logic [SW-1:0] win_sum;
  logic          more;

  logic          s1_valid_r, s1_final_r;
  logic [SW-1:0] s1_sum_r;
  logic [CW-1:0] s1_cnt_r;
  logic [IW-1:0] s1_idx_r;

  logic [SW-1:0] held_sum_r;
  logic [CW-1:0] held_cnt_r;
  logic [IW-1:0] held_idx_r;

  logic          better;
  logic [PW-1:0] prod_new, prod_held;
  logic [SW-1:0] pick_sum;
  logic [CW-1:0] pick_cnt;
  logic [IW-1:0] pick_idx;

  logic                           out_valid_r;
  logic [swmf_pkg::OUT_W-1:0]     out_data_r;

  assign stall = s1_valid_r && s1_final_r && out_valid_r && !out_tready;

  always_comb begin
    if (head.last && (head.idx < IW'(W))) begin
      start_d = head.idx[DW-1:0];
    end else begin
      start_d = DW'(W);
    end
    cur_d     = active_r ? d_r : start_d;
    need_eval = head.last || (head.idx >= IW'(W));
    more      = head.last && (cur_d != '0);
    issue     = head_valid && !stall && need_eval;
    head_pop  = head_valid && !stall && !more;
    ext       = IW'(cur_d) + IW'(W);
    lim       = (head.idx < ext) ? head.idx : ext;
    win_sum   = '0;
    for (int p = 0; p < swmf_pkg::SPAN; p++) begin
      if (IW'(p) <= lim) begin
        win_sum = win_sum + SW'(head.win[p]);
      end
    end
  end

  always_comb begin
    prod_new  = PW'(s1_sum_r) * PW'(held_cnt_r);
    prod_held = PW'(held_sum_r) * PW'(s1_cnt_r);
    better    = (held_cnt_r == '0) || (prod_new < prod_held);
    pick_sum  = better ? s1_sum_r : held_sum_r;
    pick_cnt  = better ? s1_cnt_r : held_cnt_r;
    pick_idx  = better ? s1_idx_r : held_idx_r;
  end

  always_ff @(posedge clk) begin
    s1_sum_r <= stall ? s1_sum_r : win_sum;
    s1_cnt_r <= stall ? s1_cnt_r : CW'(lim + IW'(1));
    s1_idx_r <= stall ? s1_idx_r : head.idx - IW'(cur_d);
    if (s1_valid_r && s1_final_r && !stall) begin
      out_data_r <= {swmf_pkg::OUT_CNT_W'(pick_cnt),
                     swmf_pkg::OUT_SUM_W'(pick_sum),
                     swmf_pkg::OUT_IDX_W'(pick_idx)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      d_r         <= '0;
      s1_valid_r  <= 1'b0;
      s1_final_r  <= 1'b0;
      held_sum_r  <= '0;
      held_cnt_r  <= '0;
      held_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (!stall) begin
        if (head_valid) begin
          active_r <= more;
          d_r      <= cur_d - DW'(1);
        end
        s1_valid_r <= issue;
        s1_final_r <= head.last && (cur_d == '0);
        if (s1_valid_r) begin
          if (s1_final_r) begin
            held_sum_r  <= '0;
            held_cnt_r  <= '0;
            held_idx_r  <= '0;
            out_valid_r <= 1'b1;
          end else if (better) begin
            held_sum_r <= s1_sum_r;
            held_cnt_r <= s1_cnt_r;
            held_idx_r <= s1_idx_r;
          end
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hdl/scan_window_min_finder.sv
// top level of the scan window minimum finder
//
//   channel   dir   handshake            payload
//   in_       in    tvalid/tready        tdata[15:0] range_sample, tlast sweep_last
//   out_      out   tvalid/tready        tdata[9:0] best_index, [28:10] best_sum,
//                                        [31:29] best_count
//   cfg_      in    wr_en                wr_data[15:0] range_clamp
//
// one reading per cycle while the queue has room
// the last reading of a sweep at index n issues min(n, WINDOW_HALF)+1 tail window evaluations,
// and the last of them passes through the s1 register and then the output register as the result
// a 4-entry queue lets the input keep flowing while the tail is evaluated
// the output register holds a result under stall, and new readings are still taken while the queue has room
// synchronous active-low reset, no clearing pass
module scan_window_min_finder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [15:0]                  in_tdata,    // range_sample
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [swmf_pkg::OUT_W-1:0]   out_tdata,   // best_index, best_sum, best_count
  input  logic                         cfg_wr_en,
  input  logic [15:0]                  cfg_wr_data
);

  logic               push_valid, push_ready;
  swmf_pkg::q_entry_t push_entry;
  logic               q_valid, q_pop;
  swmf_pkg::q_entry_t q_head;

  swmf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_entry  (push_entry)
  );

  swmf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_entry (push_entry),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_entry (q_head)
  );

  swmf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .head_pop   (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:29] != 3'd0) &&
                   (32'(out_tdata[31:29]) <= 32'(swmf_pkg::SPAN)))
    else $error("result count out of range");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[28:10]) <= 32'(out_tdata[31:29]) * 32'(16'hFFFF))
    else $error("result sum exceeds count of full-scale readings");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[9:0]) < 32'(swmf_pkg::MAX_READINGS))
    else $error("result index beyond sweep length");

endmodule
